// ===== sv/aptt_pkg.sv =====
// Shared types and constants of the alternating peak and trough tracker.
`default_nettype none
package aptt_pkg;

    // Ring and field sizes
    localparam int RING_DEPTH = 16;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int COUNT_W    = $clog2(RING_DEPTH + 1);
    localparam int IDX_W      = 16;
    localparam int VAL_W      = 16;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address divided by four)
    localparam logic [0:0] REG_MIN_INTERVAL = 1'b0;
    localparam logic [0:0] REG_MAX_INTERVAL = 1'b1;

    // Register reset values
    localparam logic [IDX_W-1:0] MIN_INTERVAL_RST = '0;
    localparam logic [IDX_W-1:0] MAX_INTERVAL_RST = '1;

    // Item operations
    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_SEED   = 1'b1
    } op_t;

    typedef struct packed {
        logic [IDX_W-1:0] min_interval;
        logic [IDX_W-1:0] max_interval;
    } cfg_t;

    typedef struct packed {
        op_t              operation;
        logic [IDX_W-1:0] sample_index;
        logic [VAL_W-1:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic               stored;
        logic               stored_is_top;
        logic [IDX_W-1:0]   extreme_index;
        logic [VAL_W-1:0]   extreme_value;
        logic [COUNT_W-1:0] entry_count;
        logic [SLOT_W-1:0]  oldest_slot;
    } out_item_t;

endpackage
`default_nettype wire

// ===== sv/aptt_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface aptt_in_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [aptt_pkg::IDX_W-1:0]     sample_index;
    logic [aptt_pkg::VAL_W-1:0]     sample_value;

    modport source (output valid, output operation, output sample_index,
                    output sample_value, input ready);
    modport sink   (input valid, input operation, input sample_index,
                    input sample_value, output ready);
endinterface

interface aptt_out_if;
    logic                           valid;
    logic                           ready;
    logic                           stored;
    logic                           stored_is_top;
    logic [aptt_pkg::IDX_W-1:0]     extreme_index;
    logic [aptt_pkg::VAL_W-1:0]     extreme_value;
    logic [aptt_pkg::COUNT_W-1:0]   entry_count;
    logic [aptt_pkg::SLOT_W-1:0]    oldest_slot;

    modport source (output valid, output stored, output stored_is_top,
                    output extreme_index, output extreme_value,
                    output entry_count, output oldest_slot, input ready);
    modport sink   (input valid, input stored, input stored_is_top,
                    input extreme_index, input extreme_value,
                    input entry_count, input oldest_slot, output ready);
endinterface
`default_nettype wire

// ===== sv/aptt_cfg_regs.sv =====
// APB-style configuration registers: interval limits.
`default_nettype none
module aptt_cfg_regs
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [aptt_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [aptt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [aptt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output aptt_pkg::cfg_t                           cfg
);

    logic [aptt_pkg::IDX_W-1:0] min_interval_reg;
    logic [aptt_pkg::IDX_W-1:0] max_interval_reg;
    logic                       wr_en;
    logic [0:0]                 reg_sel;

    // Zero wait states; low address bits are the byte offset
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= aptt_pkg::MIN_INTERVAL_RST;
            max_interval_reg <= aptt_pkg::MAX_INTERVAL_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                aptt_pkg::REG_MIN_INTERVAL: min_interval_reg <= pwdata[aptt_pkg::IDX_W-1:0];
                aptt_pkg::REG_MAX_INTERVAL: max_interval_reg <= pwdata[aptt_pkg::IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb
    begin
        case (reg_sel)
            aptt_pkg::REG_MIN_INTERVAL:
                prdata = {{(aptt_pkg::APB_DATA_W-aptt_pkg::IDX_W){1'b0}}, min_interval_reg};
            aptt_pkg::REG_MAX_INTERVAL:
                prdata = {{(aptt_pkg::APB_DATA_W-aptt_pkg::IDX_W){1'b0}}, max_interval_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.min_interval = min_interval_reg;
    assign cfg.max_interval = max_interval_reg;

endmodule
`default_nettype wire

// ===== sv/aptt_core.sv =====
// Tracker state and the single-pass extreme detection logic.
`default_nettype none
module aptt_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire aptt_pkg::in_item_t item,
    input  wire aptt_pkg::cfg_t     cfg,
    output aptt_pkg::out_item_t     res
);

    localparam int SLOT_W  = aptt_pkg::SLOT_W;
    localparam int COUNT_W = aptt_pkg::COUNT_W;
    localparam int IDX_W   = aptt_pkg::IDX_W;
    localparam int VAL_W   = aptt_pkg::VAL_W;

    // Ring storage, read only at the write slot (for the seed case)
    logic [IDX_W-1:0]   ring_pos_reg [aptt_pkg::RING_DEPTH];
    logic [VAL_W-1:0]   ring_amp_reg [aptt_pkg::RING_DEPTH];

    // Copies of the three most recent slots behind the write slot
    logic [IDX_W-1:0]   b1_pos_reg, b1_pos_next;
    logic [IDX_W-1:0]   b2_pos_reg, b2_pos_next;
    logic [VAL_W-1:0]   b1_amp_reg, b1_amp_next;
    logic [VAL_W-1:0]   b2_amp_reg, b2_amp_next;
    logic [VAL_W-1:0]   b3_amp_reg, b3_amp_next;

    logic [SLOT_W-1:0]  ws_reg, ws_next;
    logic [COUNT_W-1:0] kept_reg, kept_next;
    logic [SLOT_W-1:0]  oldest_reg, oldest_next;
    logic [VAL_W-1:0]   rmin_reg, rmin_next;
    logic [VAL_W-1:0]   rmax_reg, rmax_next;
    logic               ovr_reg, ovr_next;

    logic               is_bot;
    logic [VAL_W-1:0]   run_val;
    logic               keep_run;
    logic [IDX_W-1:0]   cpos;
    logic [IDX_W-1:0]   itv;
    logic [IDX_W-1:0]   itv_eff;
    logic signed [VAL_W:0]   prev_sw;
    logic signed [VAL_W:0]   curr_sw;
    logic signed [VAL_W+1:0] curr2;
    logic               swing_ok;
    logic               accept;
    logic               too_far;
    logic               push;
    logic               seed;
    logic [VAL_W-1:0]   run_next;
    logic [IDX_W-1:0]   ws_pos;
    logic [VAL_W-1:0]   ws_amp;
    logic               kept_full;

    assign ws_pos    = ring_pos_reg[ws_reg];
    assign ws_amp    = ring_amp_reg[ws_reg];
    assign kept_full = (kept_reg >= COUNT_W'(aptt_pkg::RING_DEPTH));

    // Candidate judgement and next state
    always_comb
    begin
        seed     = (item.operation == aptt_pkg::OP_SEED);
        is_bot   = ws_reg[0];
        run_val  = is_bot ? rmin_reg : rmax_reg;
        keep_run = (run_val == '0) ||
                   (is_bot ? (run_val >= item.sample_value)
                           : (run_val <= item.sample_value));
        cpos     = item.sample_index - IDX_W'(1);

        // Wrapped interval to the previous extreme of the same kind
        if (cpos > b2_pos_reg)
            itv = cpos - b2_pos_reg;
        else
            itv = cpos - b2_pos_reg - IDX_W'(1);

        // Swing test 2*curr > prev, signed
        if (is_bot)
        begin
            prev_sw = $signed({1'b0, b3_amp_reg}) - $signed({1'b0, b2_amp_reg});
            curr_sw = $signed({1'b0, b1_amp_reg}) - $signed({1'b0, run_val});
        end
        else
        begin
            prev_sw = $signed({1'b0, b2_amp_reg}) - $signed({1'b0, b3_amp_reg});
            curr_sw = $signed({1'b0, run_val}) - $signed({1'b0, b1_amp_reg});
        end
        curr2    = $signed({curr_sw, 1'b0});
        swing_ok = curr2 > $signed({prev_sw[VAL_W], prev_sw});

        // A pending overshoot forces the candidate through
        itv_eff = ovr_reg ? cfg.min_interval : itv;
        accept  = (itv_eff >= cfg.min_interval) && (itv_eff <= cfg.max_interval) &&
                  (swing_ok || ovr_reg);
        too_far = itv_eff > cfg.max_interval;

        // Defaults: hold everything
        ws_next     = ws_reg;
        kept_next   = kept_reg;
        oldest_next = oldest_reg;
        rmin_next   = rmin_reg;
        rmax_next   = rmax_reg;
        ovr_next    = ovr_reg;
        b1_pos_next = b1_pos_reg;
        b2_pos_next = b2_pos_reg;
        b1_amp_next = b1_amp_reg;
        b2_amp_next = b2_amp_reg;
        b3_amp_next = b3_amp_reg;
        push        = 1'b0;
        run_next    = run_val;

        res.stored        = 1'b0;
        res.stored_is_top = 1'b0;
        res.extreme_index = '0;
        res.extreme_value = '0;

        if (seed)
        begin
            // Seed writes slot zero and advances the write slot
            ws_next = ws_reg + SLOT_W'(1);
            if (!kept_full)
                kept_next = kept_reg + COUNT_W'(1);
            if (ws_reg == SLOT_W'(0))
            begin
                b1_pos_next = item.sample_index;
                b1_amp_next = item.sample_value;
            end
            else
            begin
                b1_pos_next = ws_pos;
                b1_amp_next = ws_amp;
            end
            if (ws_reg == SLOT_W'(1))
            begin
                b2_pos_next = item.sample_index;
                b2_amp_next = item.sample_value;
            end
            else
            begin
                b2_pos_next = b1_pos_reg;
                b2_amp_next = b1_amp_reg;
            end
            b3_amp_next = (ws_reg == SLOT_W'(2)) ? item.sample_value : b2_amp_reg;

            res.stored        = 1'b1;
            res.stored_is_top = 1'b1;
            res.extreme_index = item.sample_index;
            res.extreme_value = item.sample_value;
        end
        else
        begin
            if (keep_run)
                run_next = item.sample_value;
            else
            begin
                ovr_next = too_far && !accept;
                if (accept || too_far)
                    run_next = '0;
                push = accept;
            end

            if (push)
            begin
                ws_next = ws_reg + SLOT_W'(1);
                if (!kept_full)
                    kept_next = kept_reg + COUNT_W'(1);
                else
                    oldest_next = oldest_reg + SLOT_W'(1);
                b1_pos_next = cpos;
                b1_amp_next = run_val;
                b2_pos_next = b1_pos_reg;
                b2_amp_next = b1_amp_reg;
                b3_amp_next = b2_amp_reg;

                res.stored        = 1'b1;
                res.stored_is_top = !is_bot;
                res.extreme_index = cpos;
                res.extreme_value = run_val;
            end

            if (is_bot)
                rmin_next = run_next;
            else
                rmax_next = run_next;
        end

        res.entry_count = kept_next;
        res.oldest_slot = oldest_next;
    end

    // Control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg     <= '0;
            kept_reg   <= '0;
            oldest_reg <= '0;
            rmin_reg   <= '0;
            rmax_reg   <= '0;
            ovr_reg    <= 1'b0;
            b1_pos_reg <= '0;
            b2_pos_reg <= '0;
            b1_amp_reg <= '0;
            b2_amp_reg <= '0;
            b3_amp_reg <= '0;
        end
        else if (advance)
        begin
            ws_reg     <= ws_next;
            kept_reg   <= kept_next;
            oldest_reg <= oldest_next;
            rmin_reg   <= rmin_next;
            rmax_reg   <= rmax_next;
            ovr_reg    <= ovr_next;
            b1_pos_reg <= b1_pos_next;
            b2_pos_reg <= b2_pos_next;
            b1_amp_reg <= b1_amp_next;
            b2_amp_reg <= b2_amp_next;
            b3_amp_reg <= b3_amp_next;
        end
    end

    // Ring entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < aptt_pkg::RING_DEPTH; i++)
            begin
                ring_pos_reg[i] <= '0;
                ring_amp_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            if (seed)
            begin
                ring_pos_reg[0] <= item.sample_index;
                ring_amp_reg[0] <= item.sample_value;
            end
            else if (push)
            begin
                ring_pos_reg[ws_reg] <= cpos;
                ring_amp_reg[ws_reg] <= run_val;
            end
        end
    end

    // Entry count never passes the ring depth
    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= COUNT_W'(aptt_pkg::RING_DEPTH))
        else $error("entry count beyond ring depth");

    // Oldest slot moves only once the ring is full
    a_oldest_full: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(oldest_reg) |-> $past(kept_reg) == COUNT_W'(aptt_pkg::RING_DEPTH))
        else $error("oldest slot moved before ring was full");

    // Every stored extreme advances the write slot by one
    a_ws_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.stored |=> ws_reg == $past(ws_reg) + SLOT_W'(1))
        else $error("write slot did not advance on a store");

    // An accepted sample extreme leaves no overshoot pending and empties its running value
    a_accept_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.stored && !seed |=> !ovr_reg && (rmin_reg == '0 || rmax_reg == '0))
        else $error("state not cleared after accepted extreme");

endmodule
`default_nettype wire

// ===== sv/alternating_peak_trough_tracker_unit.sv =====
// Alternating peak and trough tracker: top level with item and result registers.
//
// Input channel in_item carries (operation, sample_index, sample_value); an item is
// taken when valid and ready are both high. operation selects a sample step or a
// seed of the zero-point top into ring entry 0. Each item yields exactly one result
// item on out_item: stored flag, kind, extreme index and value, entry count and
// oldest slot after the item.
// An accepted item is held in the input register, where the detection logic and the
// ring/state update run, and is then loaded into the result register when that has
// room. Throughput is one item per cycle while out_item.ready is high; the state
// update of one item is complete before the next leaves the input register.
// When out_item.ready is low the result register holds and one more item can wait
// in the input register; in_item.ready drops only when both are occupied.
// Reset (rst_n, asynchronous, active low) empties the ring, clears the running
// minimum/maximum and overshoot flag, and sets min_interval to 0 and max_interval
// to 65535. Configuration is written over the APB-style port: min_interval at
// byte address 0, max_interval at byte address 4, zero wait states.
`default_nettype none
module alternating_peak_trough_tracker_unit
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [aptt_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [aptt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [aptt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    aptt_in_if.sink                                  in_item,
    aptt_out_if.source                               out_item
);

    aptt_pkg::cfg_t      cfg;
    aptt_pkg::in_item_t  in_data_reg;
    aptt_pkg::out_item_t res;
    aptt_pkg::out_item_t out_data_reg;
    logic                in_vld_reg;
    logic                out_vld_reg;
    logic                advance;
    logic                take;

    aptt_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    aptt_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Handshake: move the held item into the result register when there is room
    assign advance       = in_vld_reg && (!out_vld_reg || out_item.ready);
    assign in_item.ready = !in_vld_reg || advance;
    assign take          = in_item.valid && in_item.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (take)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg.operation    <= aptt_pkg::op_t'(in_item.operation);
            in_data_reg.sample_index <= in_item.sample_index;
            in_data_reg.sample_value <= in_item.sample_value;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (out_item.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= res;
    end

    assign out_item.valid         = out_vld_reg;
    assign out_item.stored        = out_data_reg.stored;
    assign out_item.stored_is_top = out_data_reg.stored_is_top;
    assign out_item.extreme_index = out_data_reg.extreme_index;
    assign out_item.extreme_value = out_data_reg.extreme_value;
    assign out_item.entry_count   = out_data_reg.entry_count;
    assign out_item.oldest_slot   = out_data_reg.oldest_slot;

endmodule
`default_nettype wire

// ===== tb/sv/aptt_tracker_checker.sv =====
// Checker for the peak and trough tracker: watches both channels and the register port.
module aptt_tracker_checker
    import aptt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    input  wire logic [APB_DATA_W-1:0] prdata,
    input  wire logic                  pready,
    aptt_in_if                         in_mon,
    aptt_out_if                        out_mon,
    output int                         error_count,
    output int                         reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the tracker state
    logic [IDX_W-1:0]   ring_pos [RING_DEPTH];
    logic [VAL_W-1:0]   ring_amp [RING_DEPTH];
    logic [SLOT_W-1:0]  wr_slot;
    logic [SLOT_W-1:0]  oldest;
    logic [COUNT_W-1:0] kept;
    logic [VAL_W-1:0]   low_run;
    logic [VAL_W-1:0]   high_run;
    logic               overshoot;
    cfg_t               limits;

    // Extreme reports still owed by the block, oldest first
    out_item_t extreme_reports[$];

    // Distance from the previous same-kind extreme, wrapping through 0xFFFF
    function automatic logic [IDX_W-1:0] index_span(logic [IDX_W-1:0] cand,
                                                    logic [IDX_W-1:0] prev);
        if (cand > prev)
            return cand - prev;
        return (16'hFFFF - prev) + cand;
    endfunction

    // Write an accepted extreme, dropping the oldest when the ring is full
    function automatic void ring_store(logic [IDX_W-1:0] pos, logic [VAL_W-1:0] amp);
        ring_pos[wr_slot] = pos;
        ring_amp[wr_slot] = amp;
        wr_slot = wr_slot + SLOT_W'(1);
        if (kept < COUNT_W'(RING_DEPTH))
            kept = kept + COUNT_W'(1);
        else
            oldest = oldest + SLOT_W'(1);
    endfunction

    // Interval and swing test of a candidate; returns 1 when it is stored
    function automatic logic weigh_candidate(logic is_top, logic [IDX_W-1:0] cpos,
                                             logic [VAL_W-1:0] camp,
                                             logic [IDX_W-1:0] prev_pos,
                                             int prev_swing, int curr_swing);
        logic [IDX_W-1:0] span;
        logic             swing_ok;
        span     = index_span(cpos, prev_pos);
        swing_ok = (2 * curr_swing) > prev_swing;
        // a pending overshoot lets the next candidate through
        if (overshoot) begin
            overshoot = 1'b0;
            span      = limits.min_interval;
            swing_ok  = 1'b1;
        end
        if (span >= limits.min_interval && span <= limits.max_interval && swing_ok) begin
            ring_store(cpos, camp);
            if (is_top)
                high_run = '0;
            else
                low_run = '0;
            return 1'b1;
        end
        if (span > limits.max_interval) begin
            if (is_top)
                high_run = '0;
            else
                low_run = '0;
            overshoot = 1'b1;
        end
        return 1'b0;
    endfunction

    // Next-state and report for one accepted item
    function automatic out_item_t track_item(in_item_t it);
        out_item_t         r;
        logic [IDX_W-1:0]  cpos;
        logic [VAL_W-1:0]  cand;
        logic [SLOT_W-1:0] back1, back2, back3;
        int                prev_sw, curr_sw;
        r     = '0;
        cpos  = it.sample_index - IDX_W'(1);
        back1 = wr_slot - SLOT_W'(1);
        back2 = wr_slot - SLOT_W'(2);
        back3 = wr_slot - SLOT_W'(3);
        if (it.operation == OP_SEED) begin
            // zero-point top always lands in entry 0
            ring_pos[0] = it.sample_index;
            ring_amp[0] = it.sample_value;
            wr_slot = wr_slot + SLOT_W'(1);
            if (kept < COUNT_W'(RING_DEPTH))
                kept = kept + COUNT_W'(1);
            r.stored        = 1'b1;
            r.stored_is_top = 1'b1;
            r.extreme_index = it.sample_index;
            r.extreme_value = it.sample_value;
        end else if (wr_slot[0]) begin
            // odd slot: hunting a bottom
            if (low_run == '0 || low_run >= it.sample_value) begin
                low_run = it.sample_value;
            end else begin
                cand    = low_run;
                prev_sw = int'(ring_amp[back3]) - int'(ring_amp[back2]);
                curr_sw = int'(ring_amp[back1]) - int'(cand);
                if (weigh_candidate(1'b0, cpos, cand, ring_pos[back2], prev_sw, curr_sw)) begin
                    r.stored        = 1'b1;
                    r.extreme_index = cpos;
                    r.extreme_value = cand;
                end
            end
        end else begin
            // even slot: hunting a top
            if (high_run == '0 || high_run <= it.sample_value) begin
                high_run = it.sample_value;
            end else begin
                cand    = high_run;
                prev_sw = int'(ring_amp[back2]) - int'(ring_amp[back3]);
                curr_sw = int'(cand) - int'(ring_amp[back1]);
                if (weigh_candidate(1'b1, cpos, cand, ring_pos[back2], prev_sw, curr_sw)) begin
                    r.stored        = 1'b1;
                    r.stored_is_top = 1'b1;
                    r.extreme_index = cpos;
                    r.extreme_value = cand;
                end
            end
        end
        r.entry_count = kept;
        r.oldest_slot = oldest;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        out_item_t        want;
        out_item_t        got;
        logic [IDX_W-1:0] reg_val;
        int               i;
        if (!rst_n) begin
            for (i = 0; i < RING_DEPTH; i++) begin
                ring_pos[i] = '0;
                ring_amp[i] = '0;
            end
            wr_slot   = '0;
            oldest    = '0;
            kept      = '0;
            low_run   = '0;
            high_run  = '0;
            overshoot = 1'b0;
            limits.min_interval = MIN_INTERVAL_RST;
            limits.max_interval = MAX_INTERVAL_RST;
            extreme_reports.delete();
            error_count = 0;
            reports_due <= 0;
        end else begin
            // register port: follow writes, check read data
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_MIN_INTERVAL)
                        limits.min_interval = pwdata[IDX_W-1:0];
                    else
                        limits.max_interval = pwdata[IDX_W-1:0];
                end else begin
                    reg_val = (paddr[2] == REG_MIN_INTERVAL) ? limits.min_interval
                                                             : limits.max_interval;
                    check_field("prdata", {16'h0, reg_val}, prdata);
                end
            end
            // result channel
            if (out_mon.valid && out_mon.ready) begin
                got.stored        = out_mon.stored;
                got.stored_is_top = out_mon.stored_is_top;
                got.extreme_index = out_mon.extreme_index;
                got.extreme_value = out_mon.extreme_value;
                got.entry_count   = out_mon.entry_count;
                got.oldest_slot   = out_mon.oldest_slot;
                if (extreme_reports.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, actual %0h",
                             $time, got);
                    error_count++;
                end else begin
                    want = extreme_reports.pop_front();
                    check_field("stored", 32'(want.stored), 32'(got.stored));
                    check_field("stored_is_top", 32'(want.stored_is_top),
                                32'(got.stored_is_top));
                    check_field("extreme_index", 32'(want.extreme_index),
                                32'(got.extreme_index));
                    check_field("extreme_value", 32'(want.extreme_value),
                                32'(got.extreme_value));
                    check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
                    check_field("oldest_slot", 32'(want.oldest_slot), 32'(got.oldest_slot));
                end
            end
            // input channel
            if (in_mon.valid && in_mon.ready)
                extreme_reports.push_back(track_item('{operation:    op_t'(in_mon.operation),
                                                       sample_index: in_mon.sample_index,
                                                       sample_value: in_mon.sample_value}));
            reports_due <= extreme_reports.size();
        end
    end

endmodule

// ===== tb/sv/tb_alternating_peak_trough_tracker_unit.sv =====
// Testbench top: clock, reset, item and register stimulus, and the final verdict.
module tb_alternating_peak_trough_tracker_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import aptt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 141;
    localparam int HOLD_CYCLES = 200;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    errors;
    int                    reports_due;
    int                    cycle_count = 0;

    // sample generator state
    logic [IDX_W-1:0] sample_idx;
    logic [VAL_W-1:0] level;
    logic             rising;
    int               burst_left;

    aptt_in_if  in_ch();
    aptt_out_if out_ch();

    alternating_peak_trough_tracker_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_item  (in_ch),
        .out_item (out_ch)
    );

    aptt_tracker_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .error_count (errors),
        .reports_due (reports_due)
    );

    always #10 clk = ~clk;

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_alternating_peak_trough_tracker_unit: errors");
            $finish;
        end
    end

    // mostly short pauses, a few long ones
    function automatic int pause_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return 0;
        if (pick < 80)
            return $urandom_range(3, 1);
        if (pick < 95)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Offer one item and return at the edge where it is taken
    task automatic offer(op_t op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = pause_len();
            if ($urandom_range(99) < 3)
                burst_left = $urandom_range(60, 20);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= op;
        in_ch.sample_index <= idx;
        in_ch.sample_value <= val;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // Sample at the next index, with an occasional jump anywhere
    task automatic offer_next(logic [VAL_W-1:0] val);
        if ($urandom_range(99) < 3)
            sample_idx = 16'($urandom);
        else
            sample_idx = sample_idx + IDX_W'(1);
        offer(OP_SAMPLE, sample_idx, val);
    endtask

    // One register transfer: setup, access, then idle
    task automatic apb_access(logic wr, logic [APB_ADDR_W-1:0] addr,
                              logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering and wait until every result item is back
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_limits(logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi);
        logic [APB_ADDR_W-1:0] min_addr, max_addr;
        min_addr = {REG_MIN_INTERVAL, 2'b00};
        max_addr = {REG_MAX_INTERVAL, 2'b00};
        settle();
        apb_access(1'b1, min_addr, {16'($urandom), lo});
        apb_access(1'b1, max_addr, {16'($urandom), hi});
        apb_access(1'b0, min_addr, $urandom);
        apb_access(1'b0, max_addr, $urandom);
    endtask

    // Mostly alternating ramps with random shape, plus noise, zeros, seeds, repeats
    task automatic run_waveform(int n_items);
        int               sent, steps, k, pick;
        logic [VAL_W-1:0] start_level, target;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                start_level = level;
                if ($urandom_range(99) < 5)
                    target = rising ? 16'hFFFF : 16'h0001;
                else if (rising)
                    target = 16'($urandom_range(16'hFFFF, level));
                else
                    target = 16'($urandom_range(level, 1));
                steps = $urandom_range(12, 1);
                for (k = 1; k <= steps; k++) begin
                    offer_next(16'(int'(start_level)
                                   + (int'(target) - int'(start_level)) * k / steps));
                    sent++;
                end
                level  = target;
                rising = !rising;
            end else if (pick < 85) begin
                offer_next(16'($urandom));
                sent++;
            end else if (pick < 92) begin
                offer_next('0);
                sent++;
            end else if (pick < 96) begin
                offer(OP_SEED, 16'($urandom), 16'($urandom));
                sent++;
            end else begin
                // same index again
                offer(OP_SAMPLE, sample_idx, 16'($urandom));
                sent++;
            end
        end
    endtask

    // Result side: random back-pressure and long hold-offs
    initial begin : result_sink
        int   rx_left, taken, next_hold;
        logic rx_on;
        out_ch.ready <= 1'b0;
        rx_left   = 0;
        rx_on     = 1'b0;
        taken     = 0;
        next_hold = 300;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                taken++;
            if (taken >= next_hold) begin
                // hold off while the sender keeps offering, so the block backs up
                next_hold = next_hold + 500;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_on   = 1'b0;
                rx_left = 0;
            end else if (rx_left > 0) begin
                rx_left--;
            end else begin
                rx_on = !rx_on;
                if (rx_on)
                    rx_left = ($urandom_range(99) < 8) ? $urandom_range(150, 60)
                                                        : $urandom_range(8, 1);
                else
                    rx_left = pause_len();
                out_ch.ready <= rx_on;
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.operation    <= OP_SAMPLE;
        in_ch.sample_index <= '0;
        in_ch.sample_value <= '0;
        sample_idx = '0;
        level      = 16'h0800;
        rising     = 1'b1;
        burst_left = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first top from empty, through a zero and full scale
        offer(OP_SAMPLE, 16'd0, 16'h0000);
        offer(OP_SAMPLE, 16'd1, 16'h0100);
        offer(OP_SAMPLE, 16'd2, 16'hFFFF);
        offer(OP_SAMPLE, 16'd3, 16'h8000);
        // bottom hunt; a zero sample empties the running minimum
        offer(OP_SAMPLE, 16'd4, 16'h7000);
        offer(OP_SAMPLE, 16'd5, 16'h0001);
        offer(OP_SAMPLE, 16'd6, 16'h0000);
        offer(OP_SAMPLE, 16'd7, 16'h0002);
        offer(OP_SAMPLE, 16'd8, 16'h4000);
        // top too shallow for the swing test, then a deep one
        offer(OP_SAMPLE, 16'd9, 16'h5000);
        offer(OP_SAMPLE, 16'd10, 16'h4FFF);
        offer(OP_SAMPLE, 16'd11, 16'h9000);
        offer(OP_SAMPLE, 16'd12, 16'h1000);
        // zero-point seeds at both extremes
        offer(OP_SEED, 16'hFFFF, 16'hFFFF);
        offer(OP_SEED, 16'h0000, 16'h0000);
        // index wrapping through zero, and a repeated index
        offer(OP_SAMPLE, 16'hFFFE, 16'h000A);
        offer(OP_SAMPLE, 16'hFFFF, 16'h0005);
        offer(OP_SAMPLE, 16'h0000, 16'h0014);
        offer(OP_SAMPLE, 16'h0000, 16'h3000);
        offer(OP_SAMPLE, 16'h0000, 16'h2000);
        offer(OP_SAMPLE, 16'h0001, 16'hFFFF);
        offer(OP_SAMPLE, 16'h0002, 16'h0000);

        // random phases under different interval limits
        apply_limits(16'd0, 16'd0);
        run_waveform(PHASE_ITEMS);
        apply_limits(16'd3, 16'd40);
        run_waveform(PHASE_ITEMS);
        apply_limits(16'd0, 16'd20);
        run_waveform(PHASE_ITEMS);
        apply_limits(16'd10, 16'd200);
        run_waveform(PHASE_ITEMS);
        apply_limits(16'hFFFF, 16'hFFFF);
        run_waveform(PHASE_ITEMS);
        apply_limits(16'($urandom_range(63)), 16'($urandom_range(1000, 16)));
        run_waveform(PHASE_ITEMS);
        apply_limits(16'($urandom), 16'($urandom));
        run_waveform(PHASE_ITEMS);
        apply_limits(16'd0, 16'hFFFF);
        run_waveform(PHASE_ITEMS);

        settle();
        if (errors == 0)
            $display("tb_alternating_peak_trough_tracker_unit: clean");
        else
            $display("tb_alternating_peak_trough_tracker_unit: errors");
        $finish;
    end

endmodule
